// File: hw/rtl/ppp_pkg.sv
// Shared widths, types, register codes and reset values for the perspective
// point projection block. Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package ppp_pkg;

  localparam int CW    = 32;          // coordinate width
  localparam int DW    = CW + 1;      // world minus camera position
  localparam int PRW   = 16 + DW;     // coefficient times difference
  localparam int SUMW  = PRW + 2;     // sum of three products
  localparam int CAMW  = SUMW - 14;   // camera coordinate after the Q2.14 shift
  localparam int SCW   = 24;          // focal scale width
  localparam int PW    = CAMW + SCW;  // magnitude of coordinate times scale
  localparam int RW    = CAMW;        // divider remainder width
  localparam int QW    = CW + 1;      // kept quotient bits
  localparam int ROWW  = 48;
  localparam int DATAW = 64;
  localparam int ADDRW = 6;
  localparam int LATENCY = PW + 5;    // accept edge to strobe sample

  localparam logic [QW-1:0] Q_MAXPOS = {2'b00, {(CW-1){1'b1}}};
  localparam logic [QW-1:0] Q_MINMAG = {2'b01, {(CW-1){1'b0}}};

  localparam logic [2:0] REG_POS_X       = 3'd0;
  localparam logic [2:0] REG_POS_Y       = 3'd1;
  localparam logic [2:0] REG_POS_Z       = 3'd2;
  localparam logic [2:0] REG_ROW_RIGHT   = 3'd3;
  localparam logic [2:0] REG_ROW_UP      = 3'd4;
  localparam logic [2:0] REG_ROW_FORWARD = 3'd5;
  localparam logic [2:0] REG_SCALE_X     = 3'd6;
  localparam logic [2:0] REG_SCALE_Y     = 3'd7;

  localparam logic [ROWW-1:0] RST_ROW_RIGHT   = 48'h4000_0000_0000;
  localparam logic [ROWW-1:0] RST_ROW_UP      = 48'h0000_4000_0000;
  localparam logic [ROWW-1:0] RST_ROW_FORWARD = 48'h0000_0000_4000;
  localparam logic [SCW-1:0]  RST_SCALE       = 24'h01_0000;

  // One screen axis on its way through the divider chain.
  typedef struct packed {
    logic [PW-1:0] num;   // dividend bits still to be consumed, MSB first
    logic [RW-1:0] rem;
    logic [QW-1:0] q;
    logic          big;   // a quotient bit fell off the top
    logic          neg;
    logic          zpos;  // zero-depth result is the maximum
    logic          zneg;  // zero-depth result is the minimum
  } lane_t;

  typedef struct packed {
    logic          valid;
    logic          zero;
    logic [RW-1:0] den;
    lane_t         lx;
    lane_t         ly;
  } div_t;

endpackage

// File: hw/rtl/ppp_front.sv
// Front pipeline: position subtract, matrix products, row sums and the
// scale multiply that feed the divider chain. Depends on ppp_pkg.
`timescale 1ns / 1ps

module ppp_front
  import ppp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_take,
  input  logic signed [CW-1:0] world_x,
  input  logic signed [CW-1:0] world_y,
  input  logic signed [CW-1:0] world_z,
  input  logic signed [CW-1:0] pos_x,
  input  logic signed [CW-1:0] pos_y,
  input  logic signed [CW-1:0] pos_z,
  input  logic [ROWW-1:0]      row_right,
  input  logic [ROWW-1:0]      row_up,
  input  logic [ROWW-1:0]      row_forward,
  input  logic [SCW-1:0]       scale_x,
  input  logic [SCW-1:0]       scale_y,
  output div_t                 div_out
);

  logic                   v1_r, v2_r, v3_r, v4_r;
  logic signed [DW-1:0]   d_r [3];
  logic signed [PRW-1:0]  prod_r [3][3];
  logic signed [CAMW-1:0] cam_r [3];
  logic [ROWW-1:0]        rows [3];
  logic signed [SUMW-1:0] sum_w [3];
  logic [CAMW-1:0]        absx, absy, absz;
  div_t                   div_nxt, div_r;

  assign rows[0] = row_right;
  assign rows[1] = row_up;
  assign rows[2] = row_forward;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_take;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    d_r[0] <= $signed({world_x[CW-1], world_x}) - $signed({pos_x[CW-1], pos_x});
    d_r[1] <= $signed({world_y[CW-1], world_y}) - $signed({pos_y[CW-1], pos_y});
    d_r[2] <= $signed({world_z[CW-1], world_z}) - $signed({pos_z[CW-1], pos_z});
  end

  // Coefficient k of a row sits at bits [47-16k : 32-16k].
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[r][k] <= PRW'($signed(rows[r][(47 - 16*k) -: 16])) * PRW'(d_r[k]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_w[r] = SUMW'(prod_r[r][0]) + SUMW'(prod_r[r][1]) + SUMW'(prod_r[r][2]);
    end
  end

  // Floor division by 2^14 is the upper slice of the two's complement sum.
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      cam_r[r] <= sum_w[r][SUMW-1:14];
    end
  end

  always_comb begin
    absx = cam_r[0][CAMW-1] ? CAMW'(-cam_r[0]) : CAMW'(cam_r[0]);
    absy = cam_r[1][CAMW-1] ? CAMW'(-cam_r[1]) : CAMW'(cam_r[1]);
    absz = cam_r[2][CAMW-1] ? CAMW'(-cam_r[2]) : CAMW'(cam_r[2]);
    div_nxt.valid   = v3_r;
    div_nxt.zero    = (cam_r[2] == '0);
    div_nxt.den     = absz;
    div_nxt.lx.num  = PW'(absx) * PW'(scale_x);
    div_nxt.lx.rem  = '0;
    div_nxt.lx.q    = '0;
    div_nxt.lx.big  = 1'b0;
    div_nxt.lx.neg  = cam_r[0][CAMW-1] ^ cam_r[2][CAMW-1];
    div_nxt.lx.zpos = !cam_r[0][CAMW-1] && (cam_r[0] != '0) && (scale_x != '0);
    div_nxt.lx.zneg = cam_r[0][CAMW-1] && (scale_x != '0);
    div_nxt.ly.num  = PW'(absy) * PW'(scale_y);
    div_nxt.ly.rem  = '0;
    div_nxt.ly.q    = '0;
    div_nxt.ly.big  = 1'b0;
    div_nxt.ly.neg  = cam_r[1][CAMW-1] ^ cam_r[2][CAMW-1];
    div_nxt.ly.zpos = !cam_r[1][CAMW-1] && (cam_r[1] != '0) && (scale_y != '0);
    div_nxt.ly.zneg = cam_r[1][CAMW-1] && (scale_y != '0);
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
  end

  // The valid bit comes from its own reset register; the payload is not reset.
  always_comb begin
    div_out       = div_r;
    div_out.valid = v4_r;
  end

endmodule

// File: hw/rtl/ppp_div_cell.sv
// One cell of the divider chain: produces one quotient bit for both screen
// axes and passes the point on to the next cell. Depends on ppp_pkg.
`timescale 1ns / 1ps

module ppp_div_cell
  import ppp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  div_t cell_in,
  output div_t cell_out
);

  div_t out_r, out_nxt;
  logic valid_r;

  function automatic lane_t lane_step(lane_t a, logic [RW-1:0] den);
    logic [RW:0] t;
    lane_t       b;
    b     = a;
    t     = {a.rem, a.num[PW-1]};
    b.num = {a.num[PW-2:0], 1'b0};
    b.big = a.big | a.q[QW-1];
    if (t >= {1'b0, den}) begin
      b.rem = RW'(t - {1'b0, den});
      b.q   = {a.q[QW-2:0], 1'b1};
    end else begin
      b.rem = t[RW-1:0];
      b.q   = {a.q[QW-2:0], 1'b0};
    end
    return b;
  endfunction

  always_comb begin
    out_nxt    = cell_in;
    out_nxt.lx = lane_step(cell_in.lx, cell_in.den);
    out_nxt.ly = lane_step(cell_in.ly, cell_in.den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cell_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_comb begin
    cell_out       = out_r;
    cell_out.valid = valid_r;
  end

endmodule

// File: hw/rtl/ppp_sat.sv
// Result stage: sign, saturation and the zero-depth case, registered onto
// the result ports. Depends on ppp_pkg.
`timescale 1ns / 1ps

module ppp_sat
  import ppp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  div_t                 div_in,
  output logic                 out_strobe,
  output logic signed [CW-1:0] out_screen_x,
  output logic signed [CW-1:0] out_screen_y,
  output logic                 out_depth_zero,
  output logic                 out_overflow
);

  logic          strobe_r;
  logic [CW-1:0] sx_r, sy_r, sx_nxt, sy_nxt;
  logic          dz_r, ovf_r, ovfx, ovfy;

  function automatic logic [CW:0] finish(lane_t a, logic zero);
    logic [QW-1:0] nq;
    logic [CW:0]   res;   // {clipped, value}
    nq = QW'(0) - a.q;
    if (zero) begin
      if (a.zpos)      res = {1'b0, Q_MAXPOS[CW-1:0]};
      else if (a.zneg) res = {1'b0, Q_MINMAG[CW-1:0]};
      else             res = '0;
    end else if (a.neg) begin
      if (a.big || a.q > Q_MINMAG) res = {1'b1, Q_MINMAG[CW-1:0]};
      else                         res = {1'b0, nq[CW-1:0]};
    end else begin
      if (a.big || a.q > Q_MAXPOS) res = {1'b1, Q_MAXPOS[CW-1:0]};
      else                         res = {1'b0, a.q[CW-1:0]};
    end
    return res;
  endfunction

  always_comb begin
    {ovfx, sx_nxt} = finish(div_in.lx, div_in.zero);
    {ovfy, sy_nxt} = finish(div_in.ly, div_in.zero);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= div_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;
    dz_r  <= div_in.zero;
    ovf_r <= (ovfx | ovfy) & ~div_in.zero;
  end

  assign out_strobe     = strobe_r;
  assign out_screen_x   = $signed(sx_r);
  assign out_screen_y   = $signed(sy_r);
  assign out_depth_zero = dz_r;
  assign out_overflow   = ovf_r;

endmodule

// File: hw/rtl/perspective_point_projection_top.sv
// Top level of the perspective point projection block: configuration
// registers, front pipeline, divider cell chain and result stage.
// Depends on ppp_pkg, ppp_front, ppp_div_cell and ppp_sat.
//
// Usage: software writes the camera position, the three rotation rows and
// the two focal scales over the APB-style port (register i at byte address
// 8*i, 64-bit data, no wait states, reads return the stored value). A world
// point is a transaction on the input channel: it is taken at every rising
// edge where start is high and busy is low. busy is never raised, so one
// point can enter in every cycle.
// Each point yields exactly one result transaction: out_strobe is high for
// one cycle together with out_screen_x, out_screen_y, out_depth_zero and
// out_overflow. Each point passes four pipeline stages for subtract,
// multiply, sum and scale, then the restoring divider, one quotient bit per
// cell over the PW-bit product, then the registered result stage.
// Throughput is one point per cycle. The receiver cannot stall; results are
// never held. Reset clears all pipeline valid bits and restores an identity
// camera at the origin with unit scales. Configuration must be changed only
// while idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module perspective_point_projection_top
  import ppp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] in_world_x,
  input  logic signed [CW-1:0] in_world_y,
  input  logic signed [CW-1:0] in_world_z,
  // result channel
  output logic                 out_strobe,
  output logic signed [CW-1:0] out_screen_x,
  output logic signed [CW-1:0] out_screen_y,
  output logic                 out_depth_zero,
  output logic                 out_overflow,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDRW-1:0]     paddr,
  input  logic [DATAW-1:0]     pwdata,
  output logic [DATAW-1:0]     prdata,
  output logic                 pready
);

  logic signed [CW-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [ROWW-1:0]      row_right_r, row_up_r, row_forward_r;
  logic [SCW-1:0]       scale_x_r, scale_y_r;
  logic [2:0]           reg_idx;
  logic                 cfg_wr;
  logic                 in_take;
  div_t                 chain [PW+1];

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign in_take = start & ~busy;

  // The register index is the address divided by eight.
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r       <= '0;
      pos_y_r       <= '0;
      pos_z_r       <= '0;
      row_right_r   <= RST_ROW_RIGHT;
      row_up_r      <= RST_ROW_UP;
      row_forward_r <= RST_ROW_FORWARD;
      scale_x_r     <= RST_SCALE;
      scale_y_r     <= RST_SCALE;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_POS_X:       pos_x_r       <= $signed(pwdata[CW-1:0]);
        REG_POS_Y:       pos_y_r       <= $signed(pwdata[CW-1:0]);
        REG_POS_Z:       pos_z_r       <= $signed(pwdata[CW-1:0]);
        REG_ROW_RIGHT:   row_right_r   <= pwdata[ROWW-1:0];
        REG_ROW_UP:      row_up_r      <= pwdata[ROWW-1:0];
        REG_ROW_FORWARD: row_forward_r <= pwdata[ROWW-1:0];
        REG_SCALE_X:     scale_x_r     <= pwdata[SCW-1:0];
        REG_SCALE_Y:     scale_y_r     <= pwdata[SCW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POS_X:       prdata = DATAW'($unsigned(pos_x_r));
      REG_POS_Y:       prdata = DATAW'($unsigned(pos_y_r));
      REG_POS_Z:       prdata = DATAW'($unsigned(pos_z_r));
      REG_ROW_RIGHT:   prdata = DATAW'(row_right_r);
      REG_ROW_UP:      prdata = DATAW'(row_up_r);
      REG_ROW_FORWARD: prdata = DATAW'(row_forward_r);
      REG_SCALE_X:     prdata = DATAW'(scale_x_r);
      REG_SCALE_Y:     prdata = DATAW'(scale_y_r);
    endcase
  end

  ppp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_take     (in_take),
    .world_x     (in_world_x),
    .world_y     (in_world_y),
    .world_z     (in_world_z),
    .pos_x       (pos_x_r),
    .pos_y       (pos_y_r),
    .pos_z       (pos_z_r),
    .row_right   (row_right_r),
    .row_up      (row_up_r),
    .row_forward (row_forward_r),
    .scale_x     (scale_x_r),
    .scale_y     (scale_y_r),
    .div_out     (chain[0])
  );

  // One cell per dividend bit, most significant bit in the first cell.
  for (genvar i = 0; i < PW; i++) begin : g_cell
    ppp_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  ppp_sat u_sat (
    .clk            (clk),
    .rst_n          (rst_n),
    .div_in         (chain[PW]),
    .out_strobe     (out_strobe),
    .out_screen_x   (out_screen_x),
    .out_screen_y   (out_screen_y),
    .out_depth_zero (out_depth_zero),
    .out_overflow   (out_overflow)
  );

`ifndef SYNTHESIS
  // Every accepted transaction comes out after the fixed latency.
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> ##LATENCY out_strobe)
    else $error("accepted point produced no result");

  // No result without a transaction accepted that many cycles earlier.
  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_take, LATENCY))
    else $error("result without accepted point");

  // A zero-depth result never reports clipping.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_depth_zero && out_overflow))
    else $error("depth_zero and overflow both set");
`endif

endmodule

// File: dv/ppp_checker.sv
// Watches the point and result channels of the perspective projection block,
// mirrors its camera registers, predicts each projected point and compares.
// Depends on ppp_pkg for register codes and reset values.
`timescale 1ns / 1ps

module ppp_checker
  import ppp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic signed [CW-1:0] in_world_x,
  input  logic signed [CW-1:0] in_world_y,
  input  logic signed [CW-1:0] in_world_z,
  input  logic                 out_strobe,
  input  logic signed [CW-1:0] out_screen_x,
  input  logic signed [CW-1:0] out_screen_y,
  input  logic                 out_depth_zero,
  input  logic                 out_overflow,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDRW-1:0]     paddr,
  input  logic [DATAW-1:0]     pwdata,
  input  logic                 pready,
  output int                   mismatches,
  output int                   points_pending
);

  typedef struct packed {
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic          dz;
    logic          ov;
  } screen_point_t;

  logic [CW-1:0]   cam_x, cam_y, cam_z;
  logic [ROWW-1:0] row_r, row_u, row_f;
  logic [SCW-1:0]  focal_x, focal_y;
  screen_point_t   expected_points[$];

  assign points_pending = expected_points.size();

  task automatic report(input string what, input logic [CW-1:0] got,
                        input logic [CW-1:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Camera coordinate along one rotation row, floored after the Q2.14 shift.
  function automatic longint rotate(input logic [ROWW-1:0] row,
                                    input longint dx, input longint dy, input longint dz);
    longint acc;
    acc = longint'($signed(row[47:32])) * dx + longint'($signed(row[31:16])) * dy
        + longint'($signed(row[15:0])) * dz;
    return acc >>> 14;
  endfunction

  function automatic logic [CW-1:0] divide_axis(input longint c, input logic [SCW-1:0] s,
                                                input longint z, inout logic ovf);
    logic [63:0]  ac, az;
    logic [127:0] mag, q;
    logic         neg;
    neg = (c < 0) != (z < 0);
    ac  = (c < 0) ? -c : c;
    az  = (z < 0) ? -z : z;
    mag = {64'b0, ac} * {104'b0, s};
    q   = mag / {64'b0, az};
    if (neg) begin
      if (q > 128'h8000_0000) begin
        ovf = 1'b1;
        return 32'h8000_0000;
      end
      return -q[CW-1:0];
    end
    if (q > 128'h7FFF_FFFF) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return q[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] zero_depth_axis(input longint c, input logic [SCW-1:0] s);
    if (c == 0 || s == 0) return '0;
    return (c > 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  function automatic screen_point_t project_point(input logic [CW-1:0] wx,
                                                  input logic [CW-1:0] wy,
                                                  input logic [CW-1:0] wz);
    screen_point_t r;
    longint        dx, dy, dz, cx, cy, cz;
    logic          ovf;
    dx = longint'($signed(wx)) - longint'($signed(cam_x));
    dy = longint'($signed(wy)) - longint'($signed(cam_y));
    dz = longint'($signed(wz)) - longint'($signed(cam_z));
    cx = rotate(row_r, dx, dy, dz);
    cy = rotate(row_u, dx, dy, dz);
    cz = rotate(row_f, dx, dy, dz);
    ovf = 1'b0;
    if (cz == 0) begin
      r.sx = zero_depth_axis(cx, focal_x);
      r.sy = zero_depth_axis(cy, focal_y);
      r.dz = 1'b1;
      r.ov = 1'b0;
    end else begin
      r.sx = divide_axis(cx, focal_x, cz, ovf);
      r.sy = divide_axis(cy, focal_y, cz, ovf);
      r.dz = 1'b0;
      r.ov = ovf;
    end
    return r;
  endfunction

  initial mismatches = 0;

  always @(posedge clk) begin
    screen_point_t want;
    if (!rst_n) begin
      cam_x   <= '0;
      cam_y   <= '0;
      cam_z   <= '0;
      row_r   <= RST_ROW_RIGHT;
      row_u   <= RST_ROW_UP;
      row_f   <= RST_ROW_FORWARD;
      focal_x <= RST_SCALE;
      focal_y <= RST_SCALE;
      expected_points.delete();
    end else begin
      if (start && !busy)
        expected_points.push_back(project_point(in_world_x, in_world_y, in_world_z));
      if (out_strobe) begin
        if (expected_points.size() == 0) begin
          report("unexpected result", out_screen_x, '0);
        end else begin
          want = expected_points.pop_front();
          if (out_screen_x !== want.sx) report("screen_x", out_screen_x, want.sx);
          if (out_screen_y !== want.sy) report("screen_y", out_screen_y, want.sy);
          if (out_depth_zero !== want.dz)
            report("depth_zero", CW'(out_depth_zero), CW'(want.dz));
          if (out_overflow !== want.ov)
            report("overflow", CW'(out_overflow), CW'(want.ov));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_POS_X:       cam_x   <= pwdata[CW-1:0];
          REG_POS_Y:       cam_y   <= pwdata[CW-1:0];
          REG_POS_Z:       cam_z   <= pwdata[CW-1:0];
          REG_ROW_RIGHT:   row_r   <= pwdata[ROWW-1:0];
          REG_ROW_UP:      row_u   <= pwdata[ROWW-1:0];
          REG_ROW_FORWARD: row_f   <= pwdata[ROWW-1:0];
          REG_SCALE_X:     focal_x <= pwdata[SCW-1:0];
          REG_SCALE_Y:     focal_y <= pwdata[SCW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: dv/tb_perspective_point_projection_top.sv
// Testbench top for the perspective point projection block: clock, reset,
// camera set-ups over the register port, point stimulus and the verdict.
// Depends on ppp_pkg, perspective_point_projection_top and ppp_checker.
`timescale 1ns / 1ps

module tb_perspective_point_projection_top;
  import ppp_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic signed [CW-1:0] in_world_x, in_world_y, in_world_z;
  logic                 out_strobe;
  logic signed [CW-1:0] out_screen_x, out_screen_y;
  logic                 out_depth_zero, out_overflow;
  logic                 psel, penable, pwrite, pready;
  logic [ADDRW-1:0]     paddr;
  logic [DATAW-1:0]     pwdata, prdata;
  int                   mismatches, points_pending;
  int                   points_sent, camera_setups;

  localparam logic [CW-1:0] ONE = 32'h0001_0000;
  localparam logic [CW-1:0] MAXC = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] MINC = 32'h8000_0000;

  perspective_point_projection_top dut (.*);

  ppp_checker checker_i (.*);

  // 20 ns clock: 10 ns high, 10 ns low.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Safety net: the slowest legal run needs well under a tenth of this.
  initial begin
    #4_000_000;
    $display("perspective_point_projection_top test failed");
    $finish;
  end

  // One register write: a setup cycle, then an access cycle that completes on
  // the rising edge where pready is seen high. All driving is on falling edges.
  task automatic write_reg(input logic [2:0] idx, input logic [DATAW-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 3'b000};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Waits until every predicted result has come back, then lets the pipeline
  // drain for its full latency so no point is still in flight. It is entered
  // just after a falling edge, so start drops before the next rising edge.
  task automatic drain;
    start = 1'b0;
    while (points_pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_camera(input logic [CW-1:0] px, input logic [CW-1:0] py,
                            input logic [CW-1:0] pz, input logic [ROWW-1:0] rr,
                            input logic [ROWW-1:0] ru, input logic [ROWW-1:0] rf,
                            input logic [SCW-1:0] sx, input logic [SCW-1:0] sy);
    drain();
    write_reg(REG_POS_X, DATAW'(px));
    write_reg(REG_POS_Y, DATAW'(py));
    write_reg(REG_POS_Z, DATAW'(pz));
    write_reg(REG_ROW_RIGHT, DATAW'(rr));
    write_reg(REG_ROW_UP, DATAW'(ru));
    write_reg(REG_ROW_FORWARD, DATAW'(rf));
    write_reg(REG_SCALE_X, DATAW'(sx));
    write_reg(REG_SCALE_Y, DATAW'(sy));
    camera_setups++;
  endtask

  // Sends one point. The task is entered just after a falling edge; start
  // stays high across back-to-back points so it is never toggled in one step.
  task automatic send_point(input logic [CW-1:0] wx, input logic [CW-1:0] wy,
                            input logic [CW-1:0] wz, input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      = 1'b1;
    in_world_x = wx;
    in_world_y = wy;
    in_world_z = wz;
    do @(posedge clk); while (busy);
    points_sent++;
    @(negedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    logic [CW-1:0] v;
    case ($urandom_range(0, 3))
      0:       v = $urandom();
      1:       v = $urandom_range(0, 255) << 16;
      2:       v = -($urandom_range(0, 255) << 16);
      default: v = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    endcase
    return v;
  endfunction

  // A rotation coefficient, mostly near the unit range so results stay sane.
  function automatic logic [15:0] rand_coef();
    logic [15:0] v;
    if ($urandom_range(0, 3) == 0) v = 16'($urandom());
    else v = 16'($signed($urandom_range(0, 32767)) - 16384);
    return v;
  endfunction

  function automatic logic [ROWW-1:0] rand_row();
    return {rand_coef(), rand_coef(), rand_coef()};
  endfunction

  function automatic logic [SCW-1:0] rand_scale();
    logic [SCW-1:0] v;
    if ($urandom_range(0, 2) == 0) v = SCW'($urandom());
    else v = SCW'($urandom_range(1, 16) << 16);
    return v;
  endfunction

  function automatic int rand_gap();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
  endfunction

  // A random point, sometimes placed at the camera's own depth plane so the
  // zero-depth path is hit under the identity-like set-ups.
  task automatic random_points(input int count, input logic [CW-1:0] pz);
    logic [CW-1:0] wz;
    for (int i = 0; i < count; i++) begin
      wz = ($urandom_range(0, 9) == 0) ? pz : rand_coord();
      send_point(rand_coord(), rand_coord(), wz, rand_gap());
      if (i == count / 2 && $urandom_range(0, 1) == 0) drain();
    end
  endtask

  initial begin
    logic [CW-1:0] rz;
    start = 1'b0;
    in_world_x = '0;
    in_world_y = '0;
    in_world_z = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    points_sent = 0;
    camera_setups = 0;
    rst_n = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset camera: identity at the origin with unit scales.
    send_point('0, '0, '0, 0);                 // zero depth, zero offsets
    send_point(ONE, -ONE, '0, 0);              // zero depth, saturate both ways
    send_point(ONE, 2 * ONE, ONE, 0);
    send_point(MAXC, MINC, ONE, 1);            // both extremes exactly, no clipping
    send_point(ONE, ONE, -ONE, 0);             // behind the camera
    send_point(MAXC, MAXC, MAXC, 3);
    send_point(MINC, MINC, MINC, 0);
    send_point(MINC, MAXC, 1, 0);              // tiny depth
    send_point('0, '0, MINC, 0);

    // Extremes: camera at the most negative corner, the largest coefficients.
    set_camera(MINC, MINC, MINC, {16'h7FFF, 16'h8000, 16'h7FFF},
               {16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h7FFF, 16'h7FFF},
               24'hFF_FFFF, 24'hFF_FFFF);
    send_point(MAXC, MAXC, MAXC, 0);
    send_point(MINC, MINC, MINC, 0);           // all differences zero
    send_point('0, ONE, MAXC, 2);
    send_point(MAXC, MINC, '0, 0);

    // Zero scales and the most positive camera position.
    set_camera(MAXC, MAXC, MAXC, RST_ROW_RIGHT, RST_ROW_UP, RST_ROW_FORWARD, '0, '0);
    send_point(MINC, MINC, MAXC, 0);           // zero depth with zero scale
    send_point(MINC, '0, MINC, 0);
    send_point('0, MINC, ONE, 0);
    random_points(60, MAXC);

    // Identity camera again with mixed scales, then fully random set-ups.
    set_camera('0, '0, ONE, RST_ROW_RIGHT, RST_ROW_UP, RST_ROW_FORWARD,
               24'h02_0000, 24'h00_8000);
    random_points(120, ONE);
    drain();                                   // sender holds off until all is back
    random_points(60, ONE);
    repeat (4) begin
      rz = rand_coord();
      set_camera(rand_coord(), rand_coord(), rz, rand_row(), rand_row(), rand_row(),
                 rand_scale(), rand_scale());
      random_points(90, rz);
    end

    drain();
    $display("Sent %0d points over %0d camera set-ups plus the reset camera.",
             points_sent, camera_setups);
    if (mismatches == 0 && points_pending == 0) begin
      $display("perspective_point_projection_top test passed");
    end else begin
      $display("perspective_point_projection_top test failed");
    end
    $finish;
  end

endmodule
